>>> design/iep_pkg.sv
// ----------------------------------------------------------------------------
// iep_pkg
// Shared types and constants of the ICMP echo ping engine: request and
// response words, configuration register set, operation and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package iep_pkg;

    // bytes in an outgoing echo request
    localparam int PACKET_BYTES = 64;
    localparam int LEN_W        = 7;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_TICKS   = 2'd0,
        CFG_ECHO_IDENTIFIER = 2'd1
    } cfg_idx_t;

    // reset values of the configuration registers
    localparam logic [15:0] TIMEOUT_RST = 16'd20;
    localparam logic [15:0] IDENT_RST   = 16'h1234;

    // operation codes of a request word
    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RX   = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // event codes of a response word
    typedef enum logic [2:0] {
        EV_SENT    = 3'd0,
        EV_BUSY    = 3'd1,
        EV_REPLY   = 3'd2,
        EV_ANSWER  = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_t;

    // icmp type bytes
    localparam logic [7:0] ECHO_RPL_TYPE = 8'd0;
    localparam logic [7:0] ECHO_REQ_TYPE = 8'd8;

    // shortest icmp header that is looked at
    localparam logic [15:0] MIN_HDR_LEN = 16'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] target_ip;
        logic [7:0]  pkt_type;
        logic [15:0] pkt_id;
        logic [15:0] pkt_seq;
        logic [15:0] pkt_len;
        logic [31:0] src_ip;
        logic [63:0] pkt_timestamp;
    } req_word_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [31:0]      peer_ip;
        logic [7:0]       out_type;
        logic [15:0]      out_id;
        logic [15:0]      out_seq;
        logic [15:0]      out_checksum;
        logic [LEN_W-1:0] out_len;
        logic [63:0]      out_timestamp;
        logic [63:0]      round_trip;
        logic             busy_res;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] echo_identifier;
    } cfg_regs_t;

endpackage

`default_nettype wire

>>> design/iep_cfg.sv
// ----------------------------------------------------------------------------
// iep_cfg
// Configuration register file: timeout in ticks and echo identifier.
// Writes to indexes outside the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module iep_cfg
    import iep_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_regs_t                 regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    // decode the register write
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_TICKS:   regs_next.timeout_ticks   = cfg_data;
                CFG_ECHO_IDENTIFIER: regs_next.echo_identifier = cfg_data;
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout_ticks   <= TIMEOUT_RST;
            regs_reg.echo_identifier <= IDENT_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> design/iep_engine.sv
// ----------------------------------------------------------------------------
// iep_engine
// Ping state (pending flag, target, sequence, start tick, tick count) and
// the single-pass logic that turns one request word into an optional
// response word. State advances when the caller fires a word.
// ----------------------------------------------------------------------------
`default_nettype none

module iep_engine
    import iep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire req_word_t word,
    input  wire cfg_regs_t cfg,
    output logic           has_result,
    output rsp_word_t      result
);

    logic        pending_reg, pending_next;
    logic [31:0] target_reg,  target_next;
    logic [15:0] seq_reg,     seq_next;
    logic [63:0] start_reg,   start_next;
    logic [63:0] tick_reg,    tick_next;

    logic [63:0] tick_inc;
    logic [63:0] elapsed;
    logic        expired;
    logic        id_match;
    logic [18:0] req_sum;
    logic [18:0] rep_sum;

    // fold a carry-laden sum into 16 bits and complement
    function automatic logic [15:0] fold_not(input logic [18:0] sum);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

    // byte-swapped 16-bit words of the little-endian tick timestamp
    function automatic logic [18:0] le64_words(input logic [63:0] t);
        logic [18:0] s;
        s = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = s + {3'd0, t[16*k +: 8], t[16*k+8 +: 8]};
        end
        return s;
    endfunction

    // checksum sums and timeout compare
    assign req_sum  = 19'h00800 + {3'd0, cfg.echo_identifier} + {3'd0, seq_reg}
                    + le64_words(tick_reg);
    assign rep_sum  = {3'd0, word.pkt_id} + {3'd0, word.pkt_seq};
    assign tick_inc = tick_reg + 64'd1;
    assign elapsed  = tick_inc - start_reg;
    assign expired  = elapsed >= {48'd0, cfg.timeout_ticks};
    assign id_match = (word.pkt_id == cfg.echo_identifier) && (word.src_ip == target_reg);

    // next state and result word
    always_comb
    begin
        pending_next = pending_reg;
        target_next  = target_reg;
        seq_next     = seq_reg;
        start_next   = start_reg;
        tick_next    = tick_reg;
        has_result   = 1'b0;
        result       = '0;

        unique case (op_t'(word.op))
            OP_SEND:
            begin
                has_result = 1'b1;
                if (pending_reg)
                begin
                    result.event_res = EV_BUSY;
                end
                else
                begin
                    target_next          = word.target_ip;
                    pending_next         = 1'b1;
                    start_next           = tick_reg;
                    seq_next             = seq_reg + 16'd1;
                    result.event_res     = EV_SENT;
                    result.peer_ip       = word.target_ip;
                    result.out_type      = ECHO_REQ_TYPE;
                    result.out_id        = cfg.echo_identifier;
                    result.out_seq       = seq_reg;
                    result.out_checksum  = fold_not(req_sum);
                    result.out_len       = LEN_W'(PACKET_BYTES);
                    result.out_timestamp = tick_reg;
                end
            end
            OP_RX:
            begin
                if (word.pkt_len >= MIN_HDR_LEN)
                begin
                    if (word.pkt_type == ECHO_RPL_TYPE)
                    begin
                        if (pending_reg && id_match)
                        begin
                            pending_next      = 1'b0;
                            has_result        = 1'b1;
                            result.event_res  = EV_ANSWER;
                            result.peer_ip    = word.src_ip;
                            result.round_trip = tick_reg - word.pkt_timestamp;
                        end
                    end
                    else if (word.pkt_type == ECHO_REQ_TYPE)
                    begin
                        has_result          = 1'b1;
                        result.event_res    = EV_REPLY;
                        result.peer_ip      = word.src_ip;
                        result.out_type     = ECHO_RPL_TYPE;
                        result.out_id       = word.pkt_id;
                        result.out_seq      = word.pkt_seq;
                        result.out_checksum = fold_not(rep_sum);
                        result.out_len      = (word.pkt_len < 16'(PACKET_BYTES))
                                            ? word.pkt_len[LEN_W-1:0]
                                            : LEN_W'(PACKET_BYTES);
                    end
                end
            end
            OP_TICK:
            begin
                tick_next = tick_inc;
                if (pending_reg && expired)
                begin
                    pending_next      = 1'b0;
                    has_result        = 1'b1;
                    result.event_res  = EV_TIMEOUT;
                    result.round_trip = '1;
                end
            end
            OP_NONE:
            begin
                has_result = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase

        result.busy_res = pending_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            target_reg  <= '0;
            seq_reg     <= '0;
            start_reg   <= '0;
            tick_reg    <= '0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            target_reg  <= target_next;
            seq_reg     <= seq_next;
            start_reg   <= start_next;
            tick_reg    <= tick_next;
        end
    end

    // a successful send leaves a ping pending and advances the sequence
    a_send_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (word.op == OP_SEND) && !pending_reg |=> pending_reg)
        else $error("send did not set pending");

    a_send_bumps_seq: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (word.op == OP_SEND) && !pending_reg |=> seq_reg == $past(seq_reg) + 16'd1)
        else $error("sequence did not advance on send");

    // answers and timeouts only come out of a pending ping
    a_close_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && ((result.event_res == EV_ANSWER) || (result.event_res == EV_TIMEOUT))
        |-> pending_reg && !result.busy_res)
        else $error("ping closed while none pending");

    // the tick count moves only on a fired tick
    a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && (word.op == OP_TICK)) |=> tick_reg == $past(tick_reg))
        else $error("tick count moved without a tick");

endmodule

`default_nettype wire

>>> design/icmp_echo_ping_engine_unit.sv
// ----------------------------------------------------------------------------
// icmp_echo_ping_engine_unit
// ICMP echo ping engine top level: request register, engine, response
// register and the configuration register file.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_word) carries one operation per
//   word: send ping, received icmp header, or one time tick.
//   rsp channel (rsp_valid / rsp_stall / rsp_word) carries at most one
//   response word per request word, in request order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   timeout and the echo identifier; cfg_ready is always high. Write only
//   while no request word is in flight.
// Timing:
//   a request word is registered on acceptance and evaluated in the next
//   cycle; its response word is then captured in the response register,
//   which a held response can delay. One word per cycle is accepted while
//   no response is held by rsp_stall, as one combinational pass links the registers.
// Stall:
//   while rsp_stall holds a response, a request that would produce another
//   response waits in the request register and req_stall rises; requests
//   with no response (ticks, dropped headers) still pass.
// Reset:
//   rst_n clears both registers' valid flags, the ping state and the tick
//   count, and restores timeout 20 and identifier 0x1234.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_ping_engine_unit
    import iep_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_word_t            req_word,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_word_t                 rsp_word,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic      stg_vld_reg;
    req_word_t stg_word_reg;
    logic      rsp_vld_reg;
    rsp_word_t rsp_word_reg;

    cfg_regs_t cfg;
    logic      has_result;
    rsp_word_t result;
    logic      out_free;
    logic      stg_go;
    logic      req_take;

    iep_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    iep_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (stg_go),
        .word       (stg_word_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    // flow control between the two registers
    assign out_free  = !rsp_vld_reg || !rsp_stall;
    assign stg_go    = stg_vld_reg && (!has_result || out_free);
    assign req_stall = stg_vld_reg && !stg_go;
    assign req_take  = req_valid && !req_stall;

    assign rsp_valid = rsp_vld_reg;
    assign rsp_word  = rsp_word_reg;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
        end
        else if (req_take)
        begin
            stg_vld_reg <= 1'b1;
        end
        else if (stg_go)
        begin
            stg_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            stg_word_reg <= req_word;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (stg_go && has_result)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_go && has_result)
        begin
            rsp_word_reg <= result;
        end
    end

    // the request side only stalls on a held word that needs the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> stg_vld_reg && has_result && rsp_vld_reg && rsp_stall)
        else $error("request stalled without a blocked response");

    // a held response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && rsp_stall |-> !(stg_go && has_result))
        else $error("response overwritten while stalled");

    // a waiting request word is consumed or kept, never lost
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg && !stg_go |=> stg_vld_reg && $stable(stg_word_reg))
        else $error("request word lost");

endmodule

`default_nettype wire
